// ----- rtl/wfpd_pkg.sv -----
package wfpd_pkg;

   // Configuration register indexes.
   localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_GROUP_SIZE    = 2'd2;

   // Sample format codes; any other code is handled as 32 bit.
   localparam logic [1:0] FMT_16 = 2'd0;
   localparam logic [1:0] FMT_24 = 2'd1;
   localparam logic [1:0] FMT_32 = 2'd2;

   localparam int SAMPLE_W = 32;
   localparam int LEVEL_W  = 16;
   localparam int CSR_W    = 16;

   // One justified sample waiting in the input stage.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W:0]          mag;
      logic                       eos;
   } stage_type;

endpackage

// ----- rtl/waveform_peak_decimator.sv -----
// Channel   | Direction | Payload
// req_      | in        | tdata[31:0] = sample_raw, tlast = end_of_stream
// rsp_      | out       | tdata[15:0] = level, tuser = took_maximum, tlast = last
// csr_      | in        | we, addr = register index, wdata = register value
//
// A new transaction is accepted every cycle unless a result waiting on rsp_tready
// stalls the stages: one input stage registers the justified sample and its
// magnitude, and one update stage merges it into the frame and group state and
// loads the result register. Reset is synchronous and active high; it restores
// the register defaults (16 bit, two channels, groups of 100 frames) and clears
// the stream state. While a result waits on rsp_tready, one more input
// transaction is held in the input stage before req_tready drops.
module waveform_peak_decimator import wfpd_pkg::*; #(
   parameter int MAX_CHANNELS     = 8,
   parameter int GROUP_COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // Input stream.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [31:0] sample_raw
   input  logic                req_tlast,   // end_of_stream
   // Result stream.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [LEVEL_W-1:0]  rsp_tdata,   // [15:0] level
   output logic                rsp_tuser,   // took_maximum
   output logic                rsp_tlast,   // last
   // Configuration writes.
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [CSR_W-1:0]    csr_wdata
);

   localparam int CIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CHW = $clog2(MAX_CHANNELS) + 1;
   localparam int GW  = GROUP_COUNT_BITS;
   localparam int unsigned GROUP_LIM = (32'd1 << GROUP_COUNT_BITS) - 32'd1;

   // Configuration registers.
   logic [1:0]  sample_format_ff;
   logic [3:0]  channel_count_ff;
   logic [15:0] group_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= 2'd0;
         channel_count_ff <= 4'd2;
         group_size_ff    <= 16'd100;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SAMPLE_FORMAT: sample_format_ff <= csr_wdata[1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata[3:0];
            REG_GROUP_SIZE:    group_size_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Input stage: left-justify the sample and take its magnitude.
   logic        s1_valid_ff, s1_valid_in;
   stage_type   s1_ff, s1_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;
   logic        req_fire;
   logic [SAMPLE_W:0] sample_ext;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      case (sample_format_ff)
         FMT_16:  s1_in.sample = {req_tdata[15:0], 16'h0000};
         FMT_24:  s1_in.sample = {req_tdata[23:0], 8'h00};
         FMT_32:  s1_in.sample = req_tdata;
         default: s1_in.sample = req_tdata;
      endcase
      sample_ext = {s1_in.sample[SAMPLE_W-1], s1_in.sample};
      // The most negative sample has magnitude 2^31, hence the extra bit.
      s1_in.mag  = s1_in.sample[SAMPLE_W-1] ? (~sample_ext + 33'd1) : sample_ext;
      s1_in.eos  = req_tlast;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // Update stage: stream state and the result register.
   logic [CIW-1:0]             ch_idx_ff, ch_idx_in;
   logic signed [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SAMPLE_W:0]          peak_mag_ff, peak_mag_in;
   logic [GW-1:0]              fig_ff, fig_in;
   logic signed [SAMPLE_W-1:0] extreme_ff, extreme_in;
   logic                       take_max_ff, take_max_in;
   logic                       first_pending_ff, first_pending_in;

   logic [LEVEL_W-1:0]         rsp_level_ff, rsp_level_in;
   logic                       rsp_max_ff, rsp_max_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [CHW-1:0]             eff_ch;
   logic [GW-1:0]              eff_group;
   logic                       consume;
   logic                       keep_sample;
   logic signed [SAMPLE_W-1:0] new_peak;
   logic [SAMPLE_W:0]          new_mag;
   logic                       frame_done;
   logic                       take_max_eff;
   logic signed [SAMPLE_W-1:0] new_extreme;
   logic [GW-1:0]              fig_next;
   logic                       group_done;

   always_comb begin
      // Out-of-range register values are clamped to what the counters can hold.
      if (channel_count_ff == 4'd0) begin
         eff_ch = CHW'(1);
      end else if (32'(channel_count_ff) > MAX_CHANNELS) begin
         eff_ch = CHW'(MAX_CHANNELS);
      end else begin
         eff_ch = CHW'(channel_count_ff);
      end
      if (group_size_ff == 16'd0) begin
         eff_group = GW'(1);
      end else if (32'(group_size_ff) > GROUP_LIM) begin
         eff_group = '1;
      end else begin
         eff_group = GW'(group_size_ff);
      end

      consume = s1_valid_ff && advance;

      // The first channel always opens the frame; later ones win on a strictly
      // larger magnitude, so ties stay with the earlier channel.
      keep_sample = (ch_idx_ff == '0) || (s1_ff.mag > peak_mag_ff);
      new_peak    = keep_sample ? s1_ff.sample : peak_ff;
      new_mag     = keep_sample ? s1_ff.mag : peak_mag_ff;
      frame_done  = s1_ff.eos || ((CHW'(ch_idx_ff) + CHW'(1)) >= eff_ch);

      // The stream's first frame picks the direction of the first group.
      take_max_eff = first_pending_ff ? (!new_peak[SAMPLE_W-1] && (new_peak != '0))
                                      : take_max_ff;
      if (fig_ff == '0) begin
         new_extreme = new_peak;
      end else if (take_max_eff ? (new_peak > extreme_ff) : (new_peak < extreme_ff)) begin
         new_extreme = new_peak;
      end else begin
         new_extreme = extreme_ff;
      end
      fig_next   = fig_ff + GW'(1);
      group_done = fig_next >= eff_group;

      ch_idx_in        = ch_idx_ff;
      peak_in          = peak_ff;
      peak_mag_in      = peak_mag_ff;
      fig_in           = fig_ff;
      extreme_in       = extreme_ff;
      take_max_in      = take_max_ff;
      first_pending_in = first_pending_ff;
      rsp_valid_in     = advance ? 1'b0 : rsp_valid_ff;
      rsp_level_in     = new_extreme[SAMPLE_W-1 -: LEVEL_W] ^ 16'h8000;
      rsp_max_in       = take_max_eff;
      rsp_last_in      = s1_ff.eos;

      if (consume) begin
         if (!frame_done) begin
            ch_idx_in   = ch_idx_ff + CIW'(1);
            peak_in     = new_peak;
            peak_mag_in = new_mag;
         end else if (s1_ff.eos) begin
            // End of stream: flush the group and start over from reset state.
            rsp_valid_in     = 1'b1;
            ch_idx_in        = '0;
            peak_in          = '0;
            peak_mag_in      = '0;
            fig_in           = '0;
            extreme_in       = '0;
            take_max_in      = 1'b0;
            first_pending_in = 1'b1;
         end else if (group_done) begin
            rsp_valid_in     = 1'b1;
            ch_idx_in        = '0;
            fig_in           = '0;
            extreme_in       = new_extreme;
            take_max_in      = !take_max_eff;
            first_pending_in = 1'b0;
         end else begin
            ch_idx_in        = '0;
            fig_in           = fig_next;
            extreme_in       = new_extreme;
            take_max_in      = take_max_eff;
            first_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_idx_ff        <= '0;
         peak_ff          <= '0;
         peak_mag_ff      <= '0;
         fig_ff           <= '0;
         extreme_ff       <= '0;
         take_max_ff      <= 1'b0;
         first_pending_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         ch_idx_ff        <= ch_idx_in;
         peak_ff          <= peak_in;
         peak_mag_ff      <= peak_mag_in;
         fig_ff           <= fig_in;
         extreme_ff       <= extreme_in;
         take_max_ff      <= take_max_in;
         first_pending_ff <= first_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      if (advance) begin
         rsp_level_ff <= rsp_level_in;
         rsp_max_ff   <= rsp_max_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = rsp_max_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // An end-of-stream transaction leaves the stream state as after reset.
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      consume && s1_ff.eos |=> first_pending_ff && ch_idx_ff == '0 && fig_ff == '0)
      else $error("stream state not cleared after end of stream");

   // The channel index never runs past the largest frame.
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      32'(ch_idx_ff) < MAX_CHANNELS)
      else $error("channel index out of range");

   // A full group is always emitted before the frame counter can saturate.
   a_fig_range: assert property (@(posedge clock) disable iff (reset)
      fig_ff != '1)
      else $error("frame counter reached its limit");

   // Input backpressure only when both the input stage and the result are held.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without cause");
`endif

endmodule

// ----- sim/peak_level_checker.sv -----
`timescale 1ns / 1ps

// Watches the sample and level streams of the peak decimator, keeps its own copy
// of the configuration and the stream state, and compares every level
// transaction with the oldest predicted one.
module peak_level_checker import wfpd_pkg::*; #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [31:0]        req_tdata,
   input  logic               req_tlast,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [LEVEL_W-1:0] rsp_tdata,
   input  logic               rsp_tuser,
   input  logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int                 errors,
   output int                 pending
);

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               took_max;
      logic               last;
   } level_result_type;

   level_result_type expected_levels[$];

   logic [1:0]         fmt_reg;
   logic [3:0]         chan_reg;
   logic [15:0]        group_reg;

   logic [2:0]         chan_pos;
   logic signed [31:0] frame_peak;
   logic [15:0]        frames_held;
   logic signed [31:0] group_peak;
   logic               keep_max;
   logic               awaiting_first;

   function automatic logic signed [31:0] left_justify(logic [31:0] raw, logic [1:0] fmt);
      case (fmt)
         FMT_16:  return {raw[15:0], 16'h0000};
         FMT_24:  return {raw[23:0], 8'h00};
         default: return raw;
      endcase
   endfunction

   function automatic logic [32:0] magnitude(logic signed [31:0] x);
      logic signed [32:0] wide;
      wide = x;
      return (wide < 0) ? -wide : wide;
   endfunction

   task automatic clear_stream();
      chan_pos       = '0;
      frame_peak     = '0;
      frames_held    = '0;
      group_peak     = '0;
      keep_max       = 1'b0;
      awaiting_first = 1'b1;
   endtask

   // Appends one predicted level transaction behind the ones already waiting.
   task automatic queue_level(logic [LEVEL_W-1:0] level, logic took_max, logic last);
      level_result_type item;
      item.level    = level;
      item.took_max = took_max;
      item.last     = last;
      expected_levels.insert(expected_levels.size(), item);
   endtask

   // Merges one channel word into the frame and, when the frame closes, the frame
   // into the group. A closed group queues its level.
   task automatic fold_sample(logic [31:0] raw, logic eos);
      logic signed [31:0] s;
      logic [3:0]         frame_len;
      logic [15:0]        group_len;
      s = left_justify(raw, fmt_reg);
      if (chan_pos == 0 || magnitude(s) > magnitude(frame_peak))
         frame_peak = s;
      frame_len = (chan_reg == 0) ? 4'd1 :
                  (chan_reg > MAX_CHANNELS) ? 4'(MAX_CHANNELS) : chan_reg;
      if (!eos && ({1'b0, chan_pos} + 4'd1) < frame_len) begin
         chan_pos = chan_pos + 3'd1;
         return;
      end
      chan_pos = '0;
      if (awaiting_first) begin
         keep_max       = frame_peak > 0;
         awaiting_first = 1'b0;
      end
      if (frames_held == 0 || (keep_max ? frame_peak > group_peak : frame_peak < group_peak))
         group_peak = frame_peak;
      frames_held = frames_held + 16'd1;
      group_len = (group_reg == 0) ? 16'd1 : group_reg;
      if (eos) begin
         queue_level(group_peak[31:16] ^ 16'h8000, keep_max, 1'b1);
         clear_stream();
      end else if (frames_held >= group_len) begin
         queue_level(group_peak[31:16] ^ 16'h8000, keep_max, 1'b0);
         keep_max    = !keep_max;
         frames_held = '0;
      end
   endtask

   always @(posedge clock) begin
      level_result_type want;
      level_result_type got;
      if (reset) begin
         fmt_reg   = FMT_16;
         chan_reg  = 4'd2;
         group_reg = 16'd100;
         clear_stream();
         expected_levels.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_SAMPLE_FORMAT: fmt_reg   = csr_wdata[1:0];
               REG_CHANNEL_COUNT: chan_reg  = csr_wdata[3:0];
               REG_GROUP_SIZE:    group_reg = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser, rsp_tlast};
            if (expected_levels.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected level transaction: level %h took_maximum %b last %b",
                           $time, got.level, got.took_max, got.last);
               errors++;
            end else begin
               want = expected_levels.pop_front();
               if (got.level !== want.level || got.took_max !== want.took_max ||
                   got.last !== want.last) begin
                  if (errors < 10)
                     $display({"%0t: level mismatch: expected level %h took_maximum %b last %b,",
                               " got level %h took_maximum %b last %b"},
                              $time, want.level, want.took_max, want.last,
                              got.level, got.took_max, got.last);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            fold_sample(req_tdata, req_tlast);
      end
      pending <= expected_levels.size();
   end

endmodule

// ----- sim/waveform_peak_decimator_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the peak decimator. The checker beside the block does
// all prediction and comparison; this module only drives the streams and the
// register port and decides the outcome at the end.
module waveform_peak_decimator_tb;
   import wfpd_pkg::*;

   localparam int         CHANNEL_LIMIT = 8;
   // The one format code the package leaves unnamed; the block treats it as 32 bit.
   localparam logic [1:0] FMT_SPARE     = 2'd3;
   // Extra idle cycles waited at the end of a test so the block's stages can empty.
   localparam int         SETTLE_CYCLES = 8;
   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         RANDOM_PHASES = 12;
   localparam int         PHASE_WORDS   = 40;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [LEVEL_W-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;
   logic               csr_we     = 1'b0;
   logic [1:0]         csr_addr   = '0;
   logic [CSR_W-1:0]   csr_wdata  = '0;

   int          errors;
   int          pending;
   int          cycle_count = 0;
   // When set, neither side inserts idle cycles, which gives back-to-back stretches.
   logic        quiet       = 1'b0;
   // The last justified sample picked, so that a following word can tie with it.
   logic [31:0] last_sample = '0;

   waveform_peak_decimator #(
      .MAX_CHANNELS     (CHANNEL_LIMIT),
      .GROUP_COUNT_BITS (16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   peak_level_checker #(
      .MAX_CHANNELS (CHANNEL_LIMIT)
   ) level_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A hung handshake or a level that never arrives ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Idle length for either side: mostly none, often a short gap, now and
   // then a long pause.
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Picks a sample at full scale, then packs it into a raw word for the given
   // format with random junk above the used bits. Extremes, zero and exact ties
   // with the previous word are favored.
   function automatic logic [31:0] pick_sample(logic [1:0] fmt);
      logic [31:0] v;
      logic [31:0] junk;
      int          r;
      junk = $urandom;
      r = $urandom_range(0, 9);
      case (r)
         0:       v = 32'h8000_0000;
         1:       v = 32'h7FFF_FFFF;
         2:       v = 32'h0000_0000;
         3:       v = -last_sample;
         default: v = $urandom;
      endcase
      case (fmt)
         FMT_16: begin
            v[15:0] = '0;
            last_sample = v;
            return {junk[15:0], v[31:16]};
         end
         FMT_24: begin
            v[7:0] = '0;
            last_sample = v;
            return {junk[7:0], v[31:8]};
         end
         default: begin
            last_sample = v;
            return v;
         end
      endcase
   endfunction

   // Offers one channel word and returns at the edge where the transaction is
   // accepted, with req_tvalid still high so the next word can follow at once.
   task automatic push_word(logic [31:0] raw, logic eos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Writes all three registers, one per cycle. Unused upper bits of the narrow
   // registers carry junk, which the block must ignore.
   task automatic write_config(logic [1:0] fmt, logic [3:0] chans, logic [15:0] group_len);
      logic [31:0] junk;
      junk = $urandom;
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_SAMPLE_FORMAT;
      csr_wdata <= {junk[15:2], fmt};
      @(posedge clock);
      csr_addr  <= REG_CHANNEL_COUNT;
      csr_wdata <= {junk[31:20], chans};
      @(posedge clock);
      csr_addr  <= REG_GROUP_SIZE;
      csr_wdata <= group_len;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Stops offering words and waits until every predicted level has arrived. A
   // word that closes no group leaves nothing to wait for, so a few more cycles
   // let the pipeline empty before the registers may change.
   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One phase of random traffic under a random setting. Most of it is whole
   // frames with random content; some frames are cut short by an end mark and a
   // few stray words break the frame alignment. Most phases close with a flush.
   task automatic run_random_phase();
      logic [1:0]  fmt;
      logic [3:0]  chans;
      logic [15:0] group_len;
      logic        eos;
      int          frame_len;
      int          pick;
      int          n;
      int          sent;
      fmt  = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 10)
         chans = 4'd0;
      else if (pick < 20)
         chans = 4'($urandom_range(9, 15));
      else if (pick < 35)
         chans = 4'd8;
      else
         chans = 4'($urandom_range(1, 7));
      pick = $urandom_range(0, 99);
      if (pick < 8)
         group_len = 16'd0;
      else if (pick < 13)
         group_len = 16'hFFFF;
      else if (pick < 70)
         group_len = 16'($urandom_range(1, 4));
      else
         group_len = 16'($urandom_range(5, 30));
      frame_len = (chans == 0) ? 1 : (chans > CHANNEL_LIMIT) ? CHANNEL_LIMIT : int'(chans);
      quiet = ($urandom_range(0, 3) == 0);
      write_config(fmt, chans, group_len);
      sent = 0;
      while (sent < PHASE_WORDS) begin
         pick = $urandom_range(0, 99);
         n    = (pick < 80) ? frame_len : $urandom_range(1, frame_len);
         eos  = (pick < 80) ? ($urandom_range(0, 9) == 0) : (pick < 90);
         for (int k = 0; k < n; k++)
            push_word(pick_sample(fmt), eos && (k == n - 1));
         sent += n;
      end
      if ($urandom_range(0, 3) != 0)
         push_word(pick_sample(fmt), 1'b1);
      settle();
   endtask

   // Keeps rsp_tready toggling for the whole run; stalls land on every phase but the quiet ones.
   initial begin
      int stall;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 16-bit samples, two channels, one frame per level, so every frame shows.
      // The most negative sample outweighs the most positive, which also makes
      // the first group keep its minimum. Equal magnitudes keep the earlier
      // channel, junk above bit 15 is ignored, and an end mark on the first
      // channel closes a one-word frame.
      write_config(FMT_16, 4'd2, 16'd1);
      push_word(32'h0000_8000, 1'b0);
      push_word(32'h0000_7FFF, 1'b0);
      push_word(32'hABCD_0005, 1'b0);
      push_word(32'h0000_FFFB, 1'b0);
      push_word(32'h0000_1234, 1'b1);
      // A fresh stream whose first frame is exactly zero starts on the minimum.
      push_word(32'h0000_0000, 1'b0);
      push_word(32'h0000_0000, 1'b0);
      push_word(32'h0000_7FFF, 1'b1);
      settle();

      // 24-bit extremes with three channels; the end mark lands mid-frame.
      write_config(FMT_24, 4'd3, 16'd2);
      push_word(32'h0080_0000, 1'b0);
      push_word(32'h007F_FFFF, 1'b0);
      push_word(32'h0000_0001, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h0012_3456, 1'b1);
      settle();

      // 32-bit extremes, one channel, two frames per level. The stream is left
      // open on purpose so the next setting applies in the middle of it.
      write_config(FMT_32, 4'd1, 16'd2);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h0000_0001, 1'b0);
      settle();

      // The unnamed format code reads as 32 bit, a channel count of zero as one
      // and a group size of zero as one.
      write_config(FMT_SPARE, 4'd0, 16'd0);
      push_word(32'h8765_4321, 1'b0);
      push_word(32'h0123_4567, 1'b1);
      settle();

      // The largest channel code saturates to the channel limit and the largest
      // group never fills here; the end mark flushes a short frame and group.
      write_config(FMT_16, 4'd15, 16'hFFFF);
      push_word(32'h1111_0001, 1'b0);
      push_word(32'h2222_FFFF, 1'b0);
      push_word(32'h0000_7FFF, 1'b0);
      push_word(32'h0000_8001, 1'b0);
      push_word(32'h0000_0000, 1'b0);
      push_word(32'h0000_1000, 1'b1);
      settle();

      repeat (RANDOM_PHASES) run_random_phase();

      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/wfpd_pkg.sv
rtl/waveform_peak_decimator.sv
sim/peak_level_checker.sv
sim/waveform_peak_decimator_tb.sv
